>>> hw/rtl/u8sd_pkg.sv
// UTF-8 stream decoder: shared types and constants.
// Used by the front, queue, back and top-level modules. No dependencies.
package u8sd_pkg;

	localparam int CpWidth       = 21;
	localparam int QueueDepthDef = 4;

	// Lead-byte match patterns and masks
	localparam logic [7:0] MaskAscii = 8'h80;
	localparam logic [7:0] MaskLead2 = 8'hE0;
	localparam logic [7:0] PatLead2  = 8'hC0;
	localparam logic [7:0] MaskLead3 = 8'hF0;
	localparam logic [7:0] PatLead3  = 8'hE0;
	localparam logic [7:0] MaskLead4 = 8'hF8;
	localparam logic [7:0] PatLead4  = 8'hF0;
	localparam logic [7:0] MaskCont  = 8'h3F;
	localparam logic [7:0] MaskVal2  = 8'h1F;
	localparam logic [7:0] MaskVal3  = 8'h0F;
	localparam logic [7:0] MaskVal4  = 8'h07;

	// Class of a byte when read as a lead byte
	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_OTHER
	} byte_cls_t;

	// Classified byte as it travels from front to back
	typedef struct packed {
		byte_cls_t   cls;
		logic [6:0]  lead_val;  // lead payload bits, already masked
		logic [5:0]  cont_val;  // low six bits for continuation use
		logic        last;
	} tok_t;

endpackage

>>> hw/rtl/u8sd_front.sv
// Front end: classifies each incoming byte as a lead byte and builds a token.
// Depends on u8sd_pkg.
module u8sd_front import u8sd_pkg::*; (
	input  logic       in_valid,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output tok_t       push_tok,
	output logic       in_ready
);

	byte_cls_t  cls;
	logic [7:0] lead_val;

	// Lead-byte decode; order matters for the overlapping masks
	always_comb begin
		priority if (data_byte == 8'h00) begin
			cls      = CLS_ZERO;
			lead_val = 8'h00;
		end else if ((data_byte & MaskAscii) == 8'h00) begin
			cls      = CLS_ASCII;
			lead_val = data_byte;
		end else if ((data_byte & MaskLead2) == PatLead2) begin
			cls      = CLS_LEAD2;
			lead_val = data_byte & MaskVal2;
		end else if ((data_byte & MaskLead3) == PatLead3) begin
			cls      = CLS_LEAD3;
			lead_val = data_byte & MaskVal3;
		end else if ((data_byte & MaskLead4) == PatLead4) begin
			cls      = CLS_LEAD4;
			lead_val = data_byte & MaskVal4;
		end else begin
			cls      = CLS_OTHER;
			lead_val = 8'h00;
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign push_tok = '{
		cls:      cls,
		lead_val: lead_val[6:0],
		cont_val: data_byte[5:0],
		last:     last_byte
	};

endmodule

>>> hw/rtl/u8sd_queue.sv
// Small token FIFO between the classifying front and the decoding back.
// Depends on u8sd_pkg.
module u8sd_queue import u8sd_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output tok_t head_tok
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

	tok_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_pop;

	assign full      = (cnt_q == CntW'(QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head_tok  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/u8sd_back.sv
// Back end: sequence state, code point assembly and the result register.
// Depends on u8sd_pkg.
module u8sd_back import u8sd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  tok_t               tok,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CpWidth-1:0] code_point,
	output logic               char_valid,
	output logic               end_of_string,
	output logic               truncated
);

	logic [2:0]         pending_q, pending_d;
	logic [CpWidth-1:0] partial_q, partial_d;
	logic               five_q, five_d;
	logic               stopped_q, stopped_d;

	logic               emit;
	logic [CpWidth-1:0] emit_cp;
	logic               emit_char, emit_end, emit_trunc;

	logic               out_valid_q;
	logic [CpWidth-1:0] cp_q;
	logic               char_q, end_q, trunc_q;

	logic [CpWidth-1:0] shifted;
	logic [2:0]         pend_dec;

	// A token is taken whenever the result register is free or draining
	assign pop = tok_valid && (!out_valid_q || out_ready);

	assign shifted  = {partial_q[CpWidth-7:0], tok.cont_val};
	assign pend_dec = pending_q - 3'd1;

	// Next-state and result for the token at the queue head
	always_comb begin
		pending_d  = pending_q;
		partial_d  = partial_q;
		five_d     = five_q;
		stopped_d  = stopped_q;
		emit       = 1'b0;
		emit_cp    = '0;
		emit_char  = 1'b0;
		emit_end   = 1'b0;
		emit_trunc = 1'b0;

		if (stopped_q) begin
			// Text ended: drop bytes until the string's last one
			if (tok.last) begin
				emit      = 1'b1;
				emit_end  = 1'b1;
				stopped_d = 1'b0;
			end
		end else if (pending_q == 3'd0) begin
			unique case (tok.cls)
				CLS_ZERO: begin
					stopped_d = 1'b1;
				end
				CLS_ASCII: begin
					emit      = 1'b1;
					emit_cp   = CpWidth'(tok.lead_val);
					emit_char = 1'b1;
				end
				CLS_LEAD2: begin
					partial_d = CpWidth'(tok.lead_val);
					pending_d = 3'd1;
				end
				CLS_LEAD3: begin
					partial_d = CpWidth'(tok.lead_val);
					pending_d = 3'd2;
				end
				CLS_LEAD4: begin
					partial_d = CpWidth'(tok.lead_val);
					pending_d = 3'd3;
				end
				default: begin
					partial_d = '0;
					pending_d = 3'd4;
					five_d    = 1'b1;
				end
			endcase
			if (tok.last) begin
				// Last byte: finish or flag an open sequence
				if (!emit) begin
					emit       = 1'b1;
					emit_trunc = (pending_d != 3'd0);
				end
				emit_end  = 1'b1;
				pending_d = 3'd0;
				partial_d = '0;
				five_d    = 1'b0;
				stopped_d = 1'b0;
			end
		end else begin
			// Continuation byte; the 5-byte form skips its second byte
			if (!(five_q && pending_q == 3'd4)) begin
				partial_d = shifted;
			end
			pending_d = pend_dec;
			if (pend_dec == 3'd0) begin
				emit      = 1'b1;
				emit_char = 1'b1;
				emit_cp   = five_q ? CpWidth'(partial_d[15:0]) : partial_d;
				emit_end  = tok.last;
				partial_d = '0;
				five_d    = 1'b0;
			end else if (tok.last) begin
				emit       = 1'b1;
				emit_end   = 1'b1;
				emit_trunc = 1'b1;
				pending_d  = 3'd0;
				partial_d  = '0;
				five_d     = 1'b0;
			end
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			partial_q <= '0;
			five_q    <= 1'b0;
			stopped_q <= 1'b0;
		end else if (pop) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
			five_q    <= five_d;
			stopped_q <= stopped_d;
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q    <= emit_cp;
			char_q  <= emit_char;
			end_q   <= emit_end;
			trunc_q <= emit_trunc;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_point    = cp_q;
	assign char_valid    = char_q;
	assign end_of_string = end_q;
	assign truncated     = trunc_q;

endmodule

>>> hw/rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: front classifier, token queue, back decoder.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | data_byte[7:0], last_byte
//  output  | out_valid / out_ready| code_point[20:0], char_valid,
//          |                      | end_of_string, truncated
//
// One byte per cycle sustained while the output is not stalled; the back end
// decodes each byte through its state update. An accepted byte passes through
// its queue slot and then the result register before its result is valid.
// Reset clears the queue, the decoder state and the result valid flag.
// A stalled output holds the result register; the queue absorbs up to
// QueueDepth bytes before in_ready drops.
module utf8_stream_decoder_core import u8sd_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CpWidth-1:0] code_point,
	output logic               char_valid,
	output logic               end_of_string,
	output logic               truncated
);

	logic push, pop, q_full, q_not_empty;
	tok_t push_tok, head_tok;

	u8sd_front u_front (
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_tok  (push_tok),
		.in_ready  (in_ready)
	);

	u8sd_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_tok  (head_tok)
	);

	u8sd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_valid     (q_not_empty),
		.tok           (head_tok),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_point    (code_point),
		.char_valid    (char_valid),
		.end_of_string (end_of_string),
		.truncated     (truncated)
	);

endmodule
